// ===== rtl/core/dwgs_pkg.sv =====
// ----------------------------------------------------------------------------
// dwgs_pkg
// Shared constants and helper functions for the damped wave grid step unit.
// ----------------------------------------------------------------------------
package dwgs_pkg;

    localparam int GRID_SIZE  = 64;
    localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int MID_POINT  = (GRID_SIZE / 2) * GRID_SIZE + (GRID_SIZE / 2);

    localparam logic [2:0] REG_CENTRE_COEFF  = 3'd0;
    localparam logic [2:0] REG_HISTORY_COEFF = 3'd1;
    localparam logic [2:0] REG_SPATIAL_COEFF = 3'd2;
    localparam logic [2:0] REG_DRIVE_SCALE   = 3'd3;
    localparam logic [2:0] REG_TIME_WEIGHT   = 3'd4;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;

    function automatic logic signed [31:0] clamp36(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > 36'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -36'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp40(input logic signed [39:0] x);
        logic signed [31:0] r;
        if (x > 40'sh00_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -40'sh00_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [32:0] mag_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic signed [35:0] round28(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = (x + 64'sh0800_0000) >>> 28;
        return t[35:0];
    endfunction

endpackage

// ===== rtl/core/dwgs_ram.sv =====
// ----------------------------------------------------------------------------
// dwgs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dwgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/damped_wave_grid_step_unit.sv =====
// ----------------------------------------------------------------------------
// damped_wave_grid_step_unit
// Damped wave finite-difference step over a square grid held in two RAM banks.
// ----------------------------------------------------------------------------
// Channel | Dir | Signals                    | Contents
// s_      | in  | s_tdata[31:0], s_tuser     | drive_sample; operation
// m_      | out | m_tdata[95:0], m_tuser     | centre_displacement, energy; saturated
// cfg_    | in  | cfg_we, cfg_index, cfg_wdata | coefficient writes
//
// A step request sweeps all GRID_SIZE squared points, one per cycle, through the
// memory read and a six-stage pipeline, then drains until the pipeline is empty and
// presents the result. A clear request sweeps both banks with zeros and returns a
// zero result. After reset the same clearing pass runs before s_tready rises.
// A result that is not taken only holds the next request in its final state.
module damped_wave_grid_step_unit
    import dwgs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // drive_sample
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // centre_displacement, energy, zero pad
    output logic        m_tuser,   // energy_saturated
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]         state_reg;
    addr_t              k_reg;
    logic               bank_sel_reg;
    logic               reply_reg;
    logic               op_reg;
    logic signed [63:0] drive_prod_reg;

    logic signed [31:0] centre_coeff_reg, history_coeff_reg, spatial_coeff_reg;
    logic signed [31:0] drive_scale_reg;
    logic [31:0]        time_weight_reg;

    // Stage valids and payload
    logic               v1_reg, p1_reg, mid1_reg;
    addr_t              addr1_reg;
    logic               v2_reg, mid2_reg;
    addr_t              addr2_reg;
    logic signed [31:0] u2_reg, prev2_reg, lap2_reg;
    logic [32:0]        mt2_reg, mx2_reg, my2_reg;
    logic               v3_reg, mid3_reg;
    addr_t              addr3_reg;
    logic signed [63:0] pc3_reg, ph3_reg, ps3_reg;
    logic [65:0]        st3_reg, sx3_reg, sy3_reg;
    logic               v4_reg;
    addr_t              addr4_reg;
    logic signed [31:0] next4_reg;
    logic [41:0]        qt4_reg, qx4_reg, qy4_reg;
    logic               v5_reg;
    logic [57:0]        qth5_reg, qtl5_reg;
    logic [42:0]        sxy5_reg;
    logic               v6_reg;
    logic [63:0]        dens6_reg;

    logic [63:0]        acc_reg;
    logic               sat_reg;
    logic signed [31:0] centre_val_reg;

    logic signed [31:0] sh_reg [2*GRID_SIZE];

    logic               m_tvalid_reg;
    logic [95:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // Memory banks
    logic        a_we, b_we;
    addr_t       a_waddr, b_waddr, a_raddr, b_raddr;
    logic [31:0] a_wdata, b_wdata, a_rdata, b_rdata;
    logic [31:0] now_rd, before_rd;
    addr_t       p_addr;
    logic        clearing;

    assign clearing  = (state_reg == ST_CLEAR);
    assign p_addr    = k_reg - addr_t'(GRID_SIZE);
    assign a_raddr   = bank_sel_reg ? p_addr : k_reg;
    assign b_raddr   = bank_sel_reg ? k_reg : p_addr;
    assign now_rd    = bank_sel_reg ? b_rdata : a_rdata;
    assign before_rd = bank_sel_reg ? a_rdata : b_rdata;
    assign a_we      = clearing || (v4_reg && bank_sel_reg);
    assign b_we      = clearing || (v4_reg && !bank_sel_reg);
    assign a_waddr   = clearing ? k_reg : addr4_reg;
    assign b_waddr   = clearing ? k_reg : addr4_reg;
    assign a_wdata   = clearing ? 32'd0 : next4_reg;
    assign b_wdata   = clearing ? 32'd0 : next4_reg;

    dwgs_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_bank_a (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    dwgs_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_bank_b (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    // Point classification at issue
    logic [ADDR_W-1:0] k_row, k_col;
    logic              issue, interior;
    assign k_row    = ADDR_W'(k_reg / GRID_SIZE);
    assign k_col    = ADDR_W'(k_reg % GRID_SIZE);
    assign issue    = (state_reg == ST_STEP);
    assign interior = (k_row >= ADDR_W'(2)) && (k_col >= ADDR_W'(1))
                   && (k_col <= ADDR_W'(GRID_SIZE - 2));

    logic pipe_busy;
    assign pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | v6_reg;

    // Stencil window
    logic signed [31:0] w_down, w_right, w_centre, w_left, w_up;
    logic signed [35:0] lap_sum;
    assign w_down   = now_rd;
    assign w_right  = sh_reg[GRID_SIZE-2];
    assign w_centre = sh_reg[GRID_SIZE-1];
    assign w_left   = sh_reg[GRID_SIZE];
    assign w_up     = sh_reg[2*GRID_SIZE-1];
    assign lap_sum  = 36'(w_down) + 36'(w_up) + 36'(w_left) + 36'(w_right)
                    - (36'(w_centre) <<< 2);

    logic signed [39:0] next_sum;
    logic signed [63:0] drive_rnd;
    assign drive_rnd = (drive_prod_reg + 64'sh2_0000_0000) >>> 34;
    assign next_sum  = 40'(round28(pc3_reg)) + 40'(round28(ph3_reg))
                     + 40'(round28(ps3_reg)) + (mid3_reg ? 40'(drive_rnd) : 40'sd0);

    logic [64:0] acc_sum;
    assign acc_sum = {1'b0, acc_reg} + {1'b0, dens6_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            k_reg             <= '0;
            bank_sel_reg      <= 1'b0;
            reply_reg         <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            v4_reg            <= 1'b0;
            v5_reg            <= 1'b0;
            v6_reg            <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            centre_coeff_reg  <= 32'sh2000_0000;
            history_coeff_reg <= -32'sh1000_0000;
            spatial_coeff_reg <= 32'sh0400_0000;
            drive_scale_reg   <= 32'sd16384;
            time_weight_reg   <= 32'h0004_0000;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CENTRE_COEFF:  centre_coeff_reg  <= cfg_wdata;
                    REG_HISTORY_COEFF: history_coeff_reg <= cfg_wdata;
                    REG_SPATIAL_COEFF: spatial_coeff_reg <= cfg_wdata;
                    REG_DRIVE_SCALE:   drive_scale_reg   <= cfg_wdata;
                    REG_TIME_WEIGHT:   time_weight_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg && p1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= s_tuser;
                        k_reg     <= '0;
                        reply_reg <= 1'b1;
                        state_reg <= (s_tuser == OP_STEP) ? ST_STEP : ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == addr_t'(CELL_COUNT - 1)) begin
                        state_reg <= reply_reg ? ST_FIN : ST_IDLE;
                    end
                end
                ST_STEP: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == addr_t'(CELL_COUNT - 1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg    <= ST_IDLE;
                        if (op_reg == OP_STEP) begin
                            bank_sel_reg <= !bank_sel_reg;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            drive_prod_reg <= drive_scale_reg * $signed(s_tdata);
            acc_reg        <= '0;
            sat_reg        <= 1'b0;
            centre_val_reg <= '0;
        end
        p1_reg    <= interior;
        mid1_reg  <= (p_addr == addr_t'(MID_POINT));
        addr1_reg <= p_addr;
        if (v1_reg) begin
            sh_reg[0] <= now_rd;
            for (int i = 1; i < 2 * GRID_SIZE; i++) begin
                sh_reg[i] <= sh_reg[i-1];
            end
            if (p1_reg && mid1_reg) begin
                centre_val_reg <= w_centre;
            end
        end
        addr2_reg <= addr1_reg;
        mid2_reg  <= mid1_reg;
        u2_reg    <= w_centre;
        prev2_reg <= before_rd;
        lap2_reg  <= clamp36(lap_sum);
        mt2_reg   <= mag_diff(w_centre, before_rd);
        mx2_reg   <= mag_diff(w_right, w_centre);
        my2_reg   <= mag_diff(w_down, w_centre);

        addr3_reg <= addr2_reg;
        mid3_reg  <= mid2_reg;
        pc3_reg   <= centre_coeff_reg * u2_reg;
        ph3_reg   <= history_coeff_reg * prev2_reg;
        ps3_reg   <= spatial_coeff_reg * lap2_reg;
        st3_reg   <= 66'(mt2_reg) * 66'(mt2_reg);
        sx3_reg   <= 66'(mx2_reg) * 66'(mx2_reg);
        sy3_reg   <= 66'(my2_reg) * 66'(my2_reg);

        addr4_reg <= addr3_reg;
        next4_reg <= clamp40(next_sum);
        qt4_reg   <= 42'((st3_reg + 66'h80_0000) >> 24);
        qx4_reg   <= 42'((sx3_reg + 66'h80_0000) >> 24);
        qy4_reg   <= 42'((sy3_reg + 66'h80_0000) >> 24);

        qth5_reg  <= 58'(qt4_reg) * 58'(time_weight_reg[31:16]);
        qtl5_reg  <= 58'(qt4_reg) * 58'(time_weight_reg[15:0]);
        sxy5_reg  <= 43'(qx4_reg) + 43'(qy4_reg);

        dens6_reg <= 64'(qth5_reg) + 64'((qtl5_reg + 58'h8000) >> 16) + 64'(sxy5_reg);

        if (v6_reg) begin
            if (acc_sum[64]) begin
                acc_reg <= '1;
                sat_reg <= 1'b1;
            end else begin
                acc_reg <= acc_sum[63:0];
            end
        end

        if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
            if (op_reg == OP_STEP) begin
                m_tdata_reg <= {1'b0, acc_reg[63:1], centre_val_reg};
                m_tuser_reg <= sat_reg;
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !pipe_busy)
        else $error("request accepted while the pipeline still holds points");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[94:32] == {63{1'b1}}))
        else $error("saturated energy is not at full scale");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(bank_sel_reg) |-> $past(state_reg == ST_FIN))
        else $error("bank roles swapped outside the end of a step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (state_reg == ST_STEP || state_reg == ST_DRAIN))
        else $error("grid write-back outside a step sweep");
`endif

endmodule
